FILE: rtl/msgr_pkg.sv
// Package for the mid/side gain ramp block: handshake structs, state and code
// enums, register map and default constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package msgr_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int STEP_EXTRA         = 16;
  localparam int LEN_W              = 16;
  localparam int KIND_W             = 2;
  localparam int NCH                = 2;
  localparam int CH_MID             = 0;
  localparam int CH_SIDE            = 1;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 32;
  localparam logic [LEN_W-1:0] FADE_RESET = 16'd220;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_SET_MID  = 2'd1,
    KIND_SET_SIDE = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_FADE_LENGTH = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_MIX,
    ST_OUT,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic adv;
    logic mix;
    logic out_load;
    logic div_start;
    logic div_commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/msgr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Uses no package items.
`timescale 1ns / 1ps
`default_nettype none
module msgr_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial = {rem_r, nq_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[DEN_W-1:0];
      nq_nxt  = {nq_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DEN_W-1:0];
      nq_nxt  = {nq_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule
`default_nettype wire

FILE: rtl/msgr_dp.sv
// Datapath: gain ramp state, ramp and mix multipliers, output register.
// Depends on msgr_pkg and msgr_div.
`timescale 1ns / 1ps
`default_nettype none
module msgr_dp #(
  parameter int SAMPLE_BITS    = msgr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = msgr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire msgr_pkg::cmd_t                      cmd,
  output msgr_pkg::sts_t                           sts,
  input  wire logic [msgr_pkg::LEN_W-1:0]          eff_len,
  input  wire logic [msgr_pkg::KIND_W-1:0]         in_kind,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_left,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_right,
  input  wire logic signed [GAIN_FRAC_BITS+1:0]    in_gain,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [SAMPLE_BITS-1:0]                   out_left,
  output logic [SAMPLE_BITS-1:0]                   out_right
);

  localparam int SB     = SAMPLE_BITS;
  localparam int GF     = GAIN_FRAC_BITS;
  localparam int NCH    = msgr_pkg::NCH;
  localparam int LEN_W  = msgr_pkg::LEN_W;
  localparam int SX     = msgr_pkg::STEP_EXTRA;
  localparam int GAIN_W = GF + 2;
  localparam int MAG_W  = GAIN_W + SX;
  localparam int STEP_W = MAG_W + 1;
  localparam int ELAP_W = LEN_W + 1;
  localparam int PROD_W = STEP_W + ELAP_W;
  localparam int RAMP_W = PROD_W + 1 - SX;
  localparam int SUM_W  = SB + 1;
  localparam int MIX_W  = SUM_W + GAIN_W + 1;
  localparam int ACC_W  = MIX_W + 1;
  localparam int SHR_W  = ACC_W - (GF + 1);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << (GF - 1);
  localparam logic [PROD_W:0]   RND_HALF   = (PROD_W + 1)'(1) << (SX - 1);
  localparam logic [ACC_W-1:0]  MIX_HALF   = ACC_W'(1) << GF;

  function automatic logic [SB-1:0] sat_out(input logic [SHR_W-1:0] v);
    logic [SB-1:0] r;
    if (v[SHR_W-1:SB-1] == '0 || v[SHR_W-1:SB-1] == '1) begin
      r = v[SB-1:0];
    end else if (v[SHR_W-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  logic [GAIN_W-1:0]        gain_r  [NCH];
  logic [GAIN_W-1:0]        start_r [NCH];
  logic signed [STEP_W-1:0] step_r  [NCH];
  logic [LEN_W-1:0]         ltg_r   [NCH];
  logic signed [PROD_W-1:0] prod_r  [NCH];
  logic signed [ELAP_W-1:0] elap    [NCH];
  logic signed [PROD_W:0]   rnd     [NCH];
  logic signed [RAMP_W:0]   ramp    [NCH];
  logic [GAIN_W-1:0]        ramp_sat[NCH];

  logic                     sel_r;
  logic signed [GAIN_W-1:0] gv_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  dif_r;
  logic signed [MIX_W-1:0]  pm_r;
  logic signed [MIX_W-1:0]  ps_r;
  logic signed [ACC_W-1:0]  acc_a;
  logic signed [ACC_W-1:0]  acc_b;
  logic [SHR_W-1:0]         sh_a;
  logic [SHR_W-1:0]         sh_b;

  logic [GAIN_W-2:0]        target;
  logic signed [GAIN_W:0]   diff;
  logic                     neg_r;
  logic [GAIN_W-1:0]        mag;
  logic [MAG_W-1:0]         quot;
  logic                     div_done;
  logic signed [STEP_W-1:0] step_new;

  logic                     out_valid_r;
  logic [SB-1:0]            out_left_r;
  logic [SB-1:0]            out_right_r;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      elap[c] = $signed({1'b0, eff_len}) - $signed({1'b0, ltg_r[c]});
      rnd[c]  = {prod_r[c][PROD_W-1], prod_r[c]} + RND_HALF;
      ramp[c] = (RAMP_W + 1)'(rnd[c] >>> SX)
              + $signed({{(RAMP_W + 1 - GAIN_W){1'b0}}, start_r[c]});
      if (ramp[c][RAMP_W]) begin
        ramp_sat[c] = '0;
      end else if (ramp[c][RAMP_W-1:GAIN_W] != '0) begin
        ramp_sat[c] = '1;
      end else begin
        ramp_sat[c] = ramp[c][GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    target   = gv_r[GAIN_W-1] ? '0 : gv_r[GAIN_W-2:0];
    diff     = $signed({2'b00, target}) - $signed({1'b0, gain_r[sel_r]});
    mag      = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];
    step_new = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  msgr_div #(
    .NUM_W(MAG_W),
    .DEN_W(LEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  ({mag, {SX{1'b0}}}),
    .den  (eff_len),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    acc_a = ACC_W'(pm_r) + ACC_W'(ps_r) + MIX_HALF;
    acc_b = ACC_W'(pm_r) - ACC_W'(ps_r) + MIX_HALF;
    sh_a  = SHR_W'(acc_a >>> (GF + 1));
    sh_b  = SHR_W'(acc_b >>> (GF + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        gain_r[c]  <= GAIN_RESET;
        start_r[c] <= '0;
        step_r[c]  <= '0;
        ltg_r[c]   <= '0;
      end
    end else begin
      if (cmd.adv) begin
        for (int c = 0; c < NCH; c++) begin
          if (ltg_r[c] != '0) begin
            gain_r[c] <= ramp_sat[c];
            ltg_r[c]  <= ltg_r[c] - 1'b1;
          end
        end
      end
      if (cmd.div_start) begin
        start_r[sel_r] <= gain_r[sel_r];
      end
      if (cmd.div_commit) begin
        step_r[sel_r] <= step_new;
        ltg_r[sel_r]  <= eff_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sel_r <= (in_kind == msgr_pkg::KIND_SET_SIDE);
      gv_r  <= in_gain;
      sum_r <= SUM_W'(in_left) + SUM_W'(in_right);
      dif_r <= SUM_W'(in_left) - SUM_W'(in_right);
      for (int c = 0; c < NCH; c++) begin
        prod_r[c] <= PROD_W'(step_r[c]) * PROD_W'(elap[c]);
      end
    end
    if (cmd.div_start) begin
      neg_r <= diff[GAIN_W];
    end
    if (cmd.mix) begin
      pm_r <= MIX_W'(sum_r) * MIX_W'($signed({1'b0, gain_r[msgr_pkg::CH_MID]}));
      ps_r <= MIX_W'(dif_r) * MIX_W'($signed({1'b0, gain_r[msgr_pkg::CH_SIDE]}));
    end
    if (cmd.out_load) begin
      out_left_r  <= sat_out(sh_a);
      out_right_r <= sat_out(sh_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_left     = out_left_r;
  assign out_right    = out_right_r;

endmodule
`default_nettype wire

FILE: rtl/msgr_ctrl.sv
// Controller state machine: input handshake and sequencing of the datapath.
// Depends on msgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msgr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [msgr_pkg::KIND_W-1:0] in_kind,
  output logic                             in_ready,
  input  wire msgr_pkg::sts_t              sts,
  output msgr_pkg::cmd_t                   cmd
);

  msgr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      msgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_kind) inside
            msgr_pkg::KIND_SAMPLE: begin
              state_nxt = msgr_pkg::ST_ADV;
            end
            msgr_pkg::KIND_SET_MID, msgr_pkg::KIND_SET_SIDE: begin
              state_nxt = msgr_pkg::ST_DIV_START;
            end
            default: begin
              state_nxt = msgr_pkg::ST_IDLE;
            end
          endcase
        end
      end
      msgr_pkg::ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = msgr_pkg::ST_MIX;
      end
      msgr_pkg::ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = msgr_pkg::ST_OUT;
      end
      msgr_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = msgr_pkg::ST_IDLE;
        end
      end
      msgr_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = msgr_pkg::ST_DIV_WAIT;
      end
      msgr_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = msgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mid_side_gain_ramp.sv
// Mid/side stereo matrix with ramped gains. A sample request passes through
// acceptance with the ramp multiply, the ramp update, the mix multiply and the
// output saturation, which waits while the result register still holds an
// unaccepted result. A gain-set request computes its ramp step with the
// one-bit-per-cycle step divider. No new request is accepted before the last is
// done. Synchronous active-low reset restores all gains.
`timescale 1ns / 1ps
`default_nettype none
module mid_side_gain_ramp #(
  parameter int SAMPLE_BITS    = msgr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = msgr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // left_sample, right_sample, gain_value, zero padding
  input  wire logic [((2*SAMPLE_BITS+GAIN_FRAC_BITS+2+7)/8)*8-1:0] in_tdata,
  // kind
  input  wire logic [msgr_pkg::KIND_W-1:0]           in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // out_left, out_right, zero padding
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [msgr_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire logic [msgr_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [msgr_pkg::CFG_DATA_W-1:0]            cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int GAIN_W = GAIN_FRAC_BITS + 2;
  localparam int LEN_W  = msgr_pkg::LEN_W;
  localparam int OUT_W  = ((2 * SB + 7) / 8) * 8;

  logic [LEN_W-1:0]   fade_len_r;
  logic [LEN_W-1:0]   eff_len;
  logic               reg_hit;
  logic               cfg_wr;
  msgr_pkg::cmd_t     cmd;
  msgr_pkg::sts_t     sts;
  logic [SB-1:0]      res_left;
  logic [SB-1:0]      res_right;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[msgr_pkg::CFG_ADDR_W-1:2] == msgr_pkg::REG_FADE_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign cfg_prdata = reg_hit ? msgr_pkg::CFG_DATA_W'(fade_len_r) : '0;
  assign eff_len    = (fade_len_r == '0) ? LEN_W'(1) : fade_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_len_r <= msgr_pkg::FADE_RESET;
    end else if (cfg_wr) begin
      fade_len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  msgr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_kind (in_tuser),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  msgr_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .eff_len  (eff_len),
    .in_kind  (in_tuser),
    .in_left  ($signed(in_tdata[SB-1:0])),
    .in_right ($signed(in_tdata[2*SB-1:SB])),
    .in_gain  ($signed(in_tdata[2*SB+GAIN_W-1:2*SB])),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_left (res_left),
    .out_right(res_right)
  );

  assign out_tdata = OUT_W'({res_right, res_left});

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for mid_side_gain_ramp: directed table, then random
// phases at several fade lengths, results checked against an in-bench predictor.
// Depends on msgr_pkg and the mid_side_gain_ramp RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int SB     = msgr_pkg::SAMPLE_BITS_DEF;
  localparam int GF     = msgr_pkg::GAIN_FRAC_BITS_DEF;
  localparam int GB     = GF + 2;
  localparam int KIND_W = msgr_pkg::KIND_W;
  localparam int NCH    = msgr_pkg::NCH;
  localparam int CH_MID = msgr_pkg::CH_MID;
  localparam int CH_SIDE = msgr_pkg::CH_SIDE;
  localparam int SX     = msgr_pkg::STEP_EXTRA;
  localparam int ADDR_W = msgr_pkg::CFG_ADDR_W;
  localparam int DATA_W = msgr_pkg::CFG_DATA_W;
  localparam int IN_W   = ((2 * SB + GB + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * SB + 7) / 8) * 8;
  localparam longint GAIN_TOP = (longint'(1) << GB) - 1;
  localparam longint SAMP_TOP = (longint'(1) << (SB - 1)) - 1;
  localparam logic [KIND_W-1:0] K_SAMPLE   = msgr_pkg::KIND_SAMPLE;
  localparam logic [KIND_W-1:0] K_SET_MID  = msgr_pkg::KIND_SET_MID;
  localparam logic [KIND_W-1:0] K_SET_SIDE = msgr_pkg::KIND_SET_SIDE;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int LIMIT_CYCLES  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  always #5 clk = ~clk;

  mid_side_gain_ramp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  typedef struct {
    bit                is_cfg;
    logic [31:0]       fade;
    logic [KIND_W-1:0] kind;
    logic [SB-1:0]     left;
    logic [SB-1:0]     right;
    logic [GB-1:0]     gain;
    bit                typed;
    logic [2*SB-1:0]   typed_out;
  } stim_row_t;

  stim_row_t directed[$];
  logic [2*SB-1:0] mix_expect_q[$];
  logic [15:0] fade_len;
  longint ramp_gain[NCH];
  longint ramp_base[NCH];
  longint ramp_incr[NCH];
  int ramp_left[NCH];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint ramp_len();
    return (fade_len == 16'd0) ? 1 : longint'(fade_len);
  endfunction

  function automatic void retarget(int ch, logic signed [GB-1:0] raw);
    longint target;
    longint len;
    target = raw;
    if (target < 0) target = 0;
    len = ramp_len();
    ramp_base[ch] = ramp_gain[ch];
    ramp_incr[ch] = ((target - ramp_base[ch]) * (longint'(1) << SX)) / len;
    ramp_left[ch] = int'(len);
  endfunction

  function automatic void advance_ramp(int ch);
    longint elapsed;
    longint g;
    if (ramp_left[ch] == 0) return;
    elapsed = ramp_len() - ramp_left[ch];
    g = ramp_base[ch] +
        ((ramp_incr[ch] * elapsed + (longint'(1) << (SX - 1))) >>> SX);
    ramp_gain[ch] = (g < 0) ? 0 : ((g > GAIN_TOP) ? GAIN_TOP : g);
    ramp_left[ch]--;
  endfunction

  function automatic longint sat_sample(longint v);
    return (v < -SAMP_TOP - 1) ? -SAMP_TOP - 1 : ((v > SAMP_TOP) ? SAMP_TOP : v);
  endfunction

  function automatic logic [2*SB-1:0] mix_sample(logic signed [SB-1:0] l,
                                                  logic signed [SB-1:0] r);
    longint lv;
    longint rv;
    longint pm;
    longint ps;
    longint a;
    longint b;
    advance_ramp(CH_SIDE);
    advance_ramp(CH_MID);
    lv = l;
    rv = r;
    pm = (lv + rv) * ramp_gain[CH_MID];
    ps = (lv - rv) * ramp_gain[CH_SIDE];
    a = sat_sample((pm + ps + (longint'(1) << GF)) >>> (GF + 1));
    b = sat_sample((pm - ps + (longint'(1) << GF)) >>> (GF + 1));
    return {b[SB-1:0], a[SB-1:0]};
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    if ($urandom_range(0, 4) != 0) return SB'($urandom);
    case ($urandom_range(0, 3))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [GB-1:0] pick_gain();
    if ($urandom_range(0, 3) != 0) return GB'($urandom);
    case ($urandom_range(0, 3))
      0: return 18'h1FFFF;
      1: return 18'h20000;
      2: return 18'h00000;
      default: return 18'h10000;
    endcase
  endfunction

  function automatic void add_row(bit is_cfg, logic [31:0] fade, logic [KIND_W-1:0] kind,
                                  logic [SB-1:0] l, logic [SB-1:0] r, logic [GB-1:0] g,
                                  bit typed, logic [SB-1:0] el, logic [SB-1:0] er);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.fade = fade;
    row.kind = kind;
    row.left = l;
    row.right = r;
    row.gain = g;
    row.typed = typed;
    row.typed_out = {er, el};
    directed.push_back(row);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SB-1:0] l,
                           input logic [SB-1:0] r, input logic [GB-1:0] g,
                           input bit typed, input logic [2*SB-1:0] typed_out);
    logic [2*SB-1:0] pred;
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= IN_W'({g, r, l});
    do @(posedge clk); while (!in_tready);
    case (kind)
      K_SAMPLE: begin
        pred = mix_sample(l, r);
        mix_expect_q.push_back(typed ? typed_out : pred);
      end
      K_SET_MID: retarget(CH_MID, g);
      K_SET_SIDE: retarget(CH_SIDE, g);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (mix_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_fade(input logic [31:0] wval);
    logic [31:0] rd;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(4 * int'(msgr_pkg::REG_FADE_LENGTH));
    cfg_pwdata <= wval;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fade_len = wval[15:0];
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[15:0] !== wval[15:0]) begin
      $display("%0t fade_length readback: expected %h actual %h", $time, wval[15:0], rd[15:0]);
      mismatches++;
    end
  endtask

  initial begin : rx
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  always @(posedge clk) begin : check
    logic [2*SB-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_expect_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_tdata[2*SB-1:0]);
        mismatches++;
      end else begin
        want = mix_expect_q.pop_front();
        if (out_tdata[SB-1:0] !== want[SB-1:0]) begin
          $display("%0t out_left: expected %h actual %h", $time, want[SB-1:0], out_tdata[SB-1:0]);
          mismatches++;
        end
        if (out_tdata[2*SB-1:SB] !== want[2*SB-1:SB]) begin
          $display("%0t out_right: expected %h actual %h", $time, want[2*SB-1:SB],
                   out_tdata[2*SB-1:SB]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : drive
    int phase_fade[8];
    int sent;
    int pick;
    logic [KIND_W-1:0] kind;
    fade_len = msgr_pkg::FADE_RESET;
    ramp_gain[CH_MID] = longint'(1) << (GF - 1);
    ramp_gain[CH_SIDE] = longint'(1) << (GF - 1);
    for (int ch = 0; ch < NCH; ch++) begin
      ramp_base[ch] = 0;
      ramp_incr[ch] = 0;
      ramp_left[ch] = 0;
    end

    add_row(0, 0, K_SAMPLE, 24'h000000, 24'h000000, 18'h2AAAA, 1, 24'h000000, 24'h000000);
    add_row(0, 0, K_SAMPLE, 24'h7FFFFF, 24'h800000, 18'h15555, 1, 24'h400000, 24'hC00000);
    add_row(0, 0, K_SAMPLE, 24'h800000, 24'h7FFFFF, 18'h3FFFF, 1, 24'hC00000, 24'h400000);
    add_row(0, 0, K_SAMPLE, 24'hFFFFFF, 24'h000001, 18'h00000, 1, 24'h000000, 24'h000001);
    add_row(0, 0, KIND_UNUSED, 24'h7FFFFF, 24'h800000, 18'h1FFFF, 1, 0, 0);
    add_row(1, 32'hA5A5_0000, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SET_MID, 24'h7FFFFF, 24'hFFFFFF, 18'h1FFFF, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h7FFFFF, 24'h7FFFFF, 18'h2AAAA, 0, 0, 0);
    add_row(1, 32'd2, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SET_MID, 24'h800000, 24'h000000, 18'h1FFFF, 0, 0, 0);
    add_row(0, 0, K_SET_SIDE, 24'h555555, 24'hAAAAAA, 18'h20000, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h7FFFFF, 24'h7FFFFF, 18'h15555, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h800000, 24'h800000, 18'h3FFFF, 0, 0, 0);
    add_row(0, 0, K_SET_MID, 24'h000000, 24'h7FFFFF, 18'h1FFFF, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h7FFFFF, 24'h7FFFFF, 18'h00000, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h7FFFFF, 24'h800000, 18'h2AAAA, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h800000, 24'h7FFFFF, 18'h15555, 0, 0, 0);
    add_row(1, 32'h0000_FFFF, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SET_SIDE, 24'h123456, 24'h654321, 18'h1FFFF, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h123456, 24'hF6A2EF, 18'h3FFFF, 0, 0, 0);
    add_row(1, 32'd1, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h400000, 24'hC00000, 18'h00000, 0, 0, 0);
    add_row(1, 32'd3, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SET_MID, 24'h000000, 24'h000000, 18'h18000, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h3FFFFF, 24'h3FFFFF, 18'h2AAAA, 0, 0, 0);
    add_row(1, 32'h0000_FFFF, K_SAMPLE, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h3FFFFF, 24'hC00001, 18'h15555, 0, 0, 0);
    add_row(0, 0, K_SET_SIDE, 24'hFFFFFF, 24'hFFFFFF, 18'h00000, 0, 0, 0);
    add_row(0, 0, K_SAMPLE, 24'h000001, 24'hFFFFFF, 18'h1FFFF, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        program_fade(directed[i].fade);
      end else begin
        send_item(directed[i].kind, directed[i].left, directed[i].right, directed[i].gain,
                  directed[i].typed, directed[i].typed_out);
      end
    end

    phase_fade[0] = 1;
    phase_fade[1] = 65535;
    phase_fade[2] = 0;
    phase_fade[3] = 2;
    phase_fade[4] = $urandom_range(3, 40);
    phase_fade[5] = msgr_pkg::FADE_RESET;
    phase_fade[6] = $urandom_range(1, 12);
    phase_fade[7] = 5;
    for (int p = 0; p < 8; p++) begin
      settle();
      program_fade({16'($urandom), 16'(phase_fade[p])});
      calm = (p == 3);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) kind = K_SAMPLE;
        else if (pick < 82) kind = K_SET_MID;
        else if (pick < 94) kind = K_SET_SIDE;
        else kind = KIND_UNUSED;
        send_item(kind, pick_sample(), pick_sample(), pick_gain(), 0, '0);
        if (kind != KIND_UNUSED) sent++;
      end
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
